[rtl/smf_track_event_parser_top_assert.svh]
// Assertion macros used by the track parser top level.
`ifndef SMF_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`define SMF_TRACK_EVENT_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define SMF_TEP_ASSERT_NOW(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("smf_tep: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define SMF_TEP_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("smf_tep: next-cycle check failed");

`endif

[rtl/smf_tep_pkg.sv]
// Types, codes and constants of the MIDI file track parser.
`timescale 1ns / 1ps
package smf_tep_pkg;

	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_LVL_W    = $clog2(Q_DEPTH + 1);
	localparam int OUT_TICK_W = 48;

	// Event kinds on the result channel
	localparam logic [3:0] EV_NOTEOFF = 4'd0;
	localparam logic [3:0] EV_NOTEON  = 4'd1;
	localparam logic [3:0] EV_CC      = 4'd2;
	localparam logic [3:0] EV_ALLOFF  = 4'd3;
	localparam logic [3:0] EV_PROGRAM = 4'd4;
	localparam logic [3:0] EV_BEND    = 4'd5;
	localparam logic [3:0] EV_TEMPO   = 4'd6;
	localparam logic [3:0] EV_TIMESIG = 4'd7;
	localparam logic [3:0] EV_ERROR   = 4'd8;

	// Byte codes
	localparam logic [7:0] META_STATUS   = 8'hFF;
	localparam logic [7:0] META_TEMPO    = 8'h51;
	localparam logic [7:0] META_TIMESIG  = 8'h58;
	localparam logic [7:0] META_EOT      = 8'h2F;
	localparam logic [7:0] SYSEX_START   = 8'hF0;
	localparam logic [7:0] SYSEX_ESC     = 8'hF7;
	localparam logic [7:0] CC_ALL_NOTES  = 8'h7B;
	localparam logic [7:0] CC_ALL_SOUND  = 8'h78;

	// Status high nibbles
	localparam logic [3:0] ST_NOTEOFF = 4'h8;
	localparam logic [3:0] ST_NOTEON  = 4'h9;
	localparam logic [3:0] ST_POLY_AT = 4'hA;
	localparam logic [3:0] ST_CC      = 4'hB;
	localparam logic [3:0] ST_PROGRAM = 4'hC;
	localparam logic [3:0] ST_BEND    = 4'hE;

	typedef enum logic [9:0] {
		PH_DELTA      = 10'b00_0000_0001,
		PH_STATUS     = 10'b00_0000_0010,
		PH_META_TYPE  = 10'b00_0000_0100,
		PH_META_LEN   = 10'b00_0000_1000,
		PH_META_BODY  = 10'b00_0001_0000,
		PH_SYSEX_LEN  = 10'b00_0010_0000,
		PH_SYSEX_BODY = 10'b00_0100_0000,
		PH_DATA1      = 10'b00_1000_0000,
		PH_DATA2      = 10'b01_0000_0000,
		PH_IDLE       = 10'b10_0000_0000
	} phase_t;

	typedef enum logic [1:0] {
		CLS_DATA   = 2'd0,
		CLS_STATUS = 2'd1,
		CLS_META   = 2'd2,
		CLS_SYSEX  = 2'd3
	} byte_cls_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       start;
		logic       last;
		byte_cls_t  cls;
	} q_entry_t;

	typedef struct packed {
		logic               not_empty;
		logic               full;
		logic [Q_LVL_W-1:0] level;
	} q_stat_t;

	typedef struct packed {
		logic [3:0]            kind;
		logic [3:0]            channel;
		logic [7:0]            data_a;
		logic [7:0]            data_b;
		logic [23:0]           tempo;
		logic [OUT_TICK_W-1:0] tick;
	} evt_t;

	// Channel messages that carry two data bytes
	function automatic logic takes_two(input logic [7:0] st);
		logic two;
		two = 1'b0;
		case (st[7:4]) inside
			ST_NOTEOFF, ST_NOTEON, ST_POLY_AT, ST_CC, ST_BEND: two = 1'b1;
			default: two = 1'b0;
		endcase
		return two;
	endfunction

endpackage

[rtl/smf_tep_in_if.sv]
// Byte request channel of the track parser.
`timescale 1ns / 1ps
interface smf_tep_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       track_start;
	logic       last_in_track;

	modport source (output valid, byte_value, track_start, last_in_track, input ready);
	modport sink   (input valid, byte_value, track_start, last_in_track, output ready);
endinterface

[rtl/smf_tep_out_if.sv]
// Event request channel of the track parser.
`timescale 1ns / 1ps
interface smf_tep_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_kind;
	logic [3:0]  channel;
	logic [7:0]  data_a;
	logic [7:0]  data_b;
	logic [23:0] tempo_usec;
	logic [47:0] tick_offset;

	modport source (output valid, event_kind, channel, data_a, data_b, tempo_usec,
		tick_offset, input ready);
	modport sink   (input valid, event_kind, channel, data_a, data_b, tempo_usec,
		tick_offset, output ready);
endinterface

[rtl/smf_tep_front.sv]
// Front end: accept bytes and classify them for the parser.
`timescale 1ns / 1ps
module smf_tep_front
	import smf_tep_pkg::*;
(
	smf_tep_in_if.sink bytes,
	input  q_stat_t    qstat,
	output logic       push,
	output q_entry_t   push_data
);

	byte_cls_t cls;

	always_comb begin
		unique case (bytes.byte_value) inside
			META_STATUS:            cls = CLS_META;
			SYSEX_START, SYSEX_ESC: cls = CLS_SYSEX;
			default:                cls = bytes.byte_value[7] ? CLS_STATUS : CLS_DATA;
		endcase
	end

	assign bytes.ready = !qstat.full;
	assign push        = bytes.valid && !qstat.full;

	assign push_data.byte_value = bytes.byte_value;
	assign push_data.start      = bytes.track_start;
	assign push_data.last       = bytes.last_in_track;
	assign push_data.cls        = cls;

endmodule

[rtl/smf_tep_queue.sv]
// Short queue of classified bytes between front and back.
`timescale 1ns / 1ps
module smf_tep_queue
	import smf_tep_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	input  logic     pop,
	output q_entry_t head,
	output q_stat_t  qstat
);

	q_entry_t           mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_LVL_W-1:0] level_q;

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		logic [Q_PTR_W-1:0] r;
		if (p == Q_PTR_W'(Q_DEPTH - 1)) r = '0;
		else r = p + Q_PTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			case ({push, pop})
				2'b10:   level_q <= level_q + Q_LVL_W'(1);
				2'b01:   level_q <= level_q - Q_LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	assign head            = mem_q[rd_ptr_q];
	assign qstat.not_empty = (level_q != '0);
	assign qstat.full      = (level_q == Q_LVL_W'(Q_DEPTH));
	assign qstat.level     = level_q;

endmodule

[rtl/smf_tep_back.sv]
// Back end: parse state machine and result register.
`timescale 1ns / 1ps
module smf_tep_back
	import smf_tep_pkg::*;
#(
	parameter int TICK_BITS = 48
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     bpm_override,
	input  q_entry_t head,
	input  q_stat_t  qstat,
	output logic     pop,
	smf_tep_out_if.source events
);

	localparam int EXT_W = (TICK_BITS > OUT_TICK_W) ? TICK_BITS : OUT_TICK_W;

	phase_t               phase_q;
	logic [7:0]           run_q, cur_q, meta_q, first_q;
	logic [31:0]          varlen_q, skip_q;
	logic [23:0]          cap_q;
	logic [TICK_BITS-1:0] tick_q;
	logic                 done_q;

	phase_t               ph_e, ph_d;
	logic [7:0]           run_e, run_d, cur_e, cur_d, meta_e, first_e, first_d, meta_d;
	logic [31:0]          varlen_e, varlen_d, skip_e, skip_d, vacc, meta_len;
	logic [23:0]          cap_e, cap_d;
	logic [TICK_BITS-1:0] tick_e, tick_d;
	logic [TICK_BITS:0]   tick_sum;
	logic                 done_e, done_d;
	logic                 complete, err, fin_chan, fin_meta;
	logic [7:0]           d1, d2, b;
	logic                 ev_hit;
	evt_t                 ev, evt_q;
	logic                 evt_valid_q;
	logic                 advance;
	logic [EXT_W-1:0]     tick_ext;

	assign b        = head.byte_value;
	assign tick_sum = {1'b0, tick_e} + (TICK_BITS + 1)'(vacc);

	always_comb begin
		// restart of a track clears the parse state before the byte
		ph_e     = phase_q;
		run_e    = run_q;
		cur_e    = cur_q;
		meta_e   = meta_q;
		first_e  = first_q;
		varlen_e = varlen_q;
		skip_e   = skip_q;
		cap_e    = cap_q;
		tick_e   = tick_q;
		done_e   = done_q;
		if (head.start) begin
			ph_e     = PH_DELTA;
			run_e    = '0;
			cur_e    = '0;
			meta_e   = '0;
			first_e  = '0;
			varlen_e = '0;
			skip_e   = '0;
			cap_e    = '0;
			tick_e   = '0;
			done_e   = 1'b0;
		end
		vacc = {varlen_e[24:0], b[6:0]};

		ph_d     = ph_e;
		run_d    = run_e;
		cur_d    = cur_e;
		meta_d   = meta_e;
		first_d  = first_e;
		varlen_d = varlen_e;
		skip_d   = skip_e;
		cap_d    = cap_e;
		tick_d   = tick_e;
		done_d   = done_e;
		complete = 1'b0;
		err      = 1'b0;
		fin_chan = 1'b0;
		fin_meta = 1'b0;
		d1       = '0;
		d2       = '0;
		meta_len = '0;
		ev_hit   = 1'b0;
		ev       = '0;

		if (!done_e && ph_e != PH_IDLE) begin
			unique case (ph_e)
				PH_DELTA: begin
					varlen_d = vacc;
					if (!b[7]) begin
						tick_d = tick_sum[TICK_BITS] ? '1 : tick_sum[TICK_BITS-1:0];
						ph_d   = PH_STATUS;
					end
				end
				PH_STATUS: begin
					unique case (head.cls)
						CLS_META: ph_d = PH_META_TYPE;
						CLS_SYSEX: begin
							varlen_d = '0;
							ph_d     = PH_SYSEX_LEN;
						end
						CLS_DATA: begin
							if (run_e == '0) begin
								err = 1'b1;
							end else begin
								cur_d   = run_e;
								first_d = b;
								if (takes_two(run_e)) begin
									ph_d = PH_DATA2;
								end else begin
									fin_chan = 1'b1;
									d1       = b;
								end
							end
						end
						default: begin
							run_d = b;
							cur_d = b;
							ph_d  = PH_DATA1;
						end
					endcase
				end
				PH_DATA1: begin
					first_d = b;
					if (takes_two(cur_e)) begin
						ph_d = PH_DATA2;
					end else begin
						fin_chan = 1'b1;
						d1       = b;
					end
				end
				PH_DATA2: begin
					fin_chan = 1'b1;
					d1       = first_e;
					d2       = b;
				end
				PH_META_TYPE: begin
					meta_d   = b;
					varlen_d = '0;
					ph_d     = PH_META_LEN;
				end
				PH_META_LEN: begin
					varlen_d = vacc;
					if (!b[7]) begin
						skip_d  = vacc;
						first_d = '0;
						cap_d   = '0;
						if (vacc == '0) fin_meta = 1'b1;
						else ph_d = PH_META_BODY;
					end
				end
				PH_META_BODY: begin
					if (varlen_e == skip_e) first_d = b;
					cap_d  = {cap_e[15:0], b};
					skip_d = skip_e - 32'd1;
					if (skip_e == 32'd1) fin_meta = 1'b1;
				end
				PH_SYSEX_LEN: begin
					varlen_d = vacc;
					if (!b[7]) begin
						skip_d   = vacc;
						varlen_d = '0;
						if (vacc == '0) begin
							ph_d     = PH_DELTA;
							complete = 1'b1;
						end else begin
							ph_d = PH_SYSEX_BODY;
						end
					end
				end
				PH_SYSEX_BODY: begin
					skip_d = skip_e - 32'd1;
					if (skip_e == 32'd1) begin
						ph_d     = PH_DELTA;
						varlen_d = '0;
						complete = 1'b1;
					end
				end
				default: ph_d = ph_e;
			endcase

			if (fin_chan) begin
				ev.channel = cur_d[3:0];
				case (cur_d[7:4])
					ST_NOTEOFF: begin
						ev_hit    = 1'b1;
						ev.kind   = EV_NOTEOFF;
						ev.data_a = d1;
					end
					ST_NOTEON: begin
						ev_hit    = 1'b1;
						ev.data_a = d1;
						if (d2 == '0) begin
							ev.kind = EV_NOTEOFF;
						end else begin
							ev.kind   = EV_NOTEON;
							ev.data_b = d2;
						end
					end
					ST_CC: begin
						ev_hit = 1'b1;
						if (d1 == CC_ALL_NOTES || d1 == CC_ALL_SOUND) begin
							ev.kind = EV_ALLOFF;
						end else begin
							ev.kind   = EV_CC;
							ev.data_a = d1;
							ev.data_b = d2;
						end
					end
					ST_PROGRAM: begin
						ev_hit    = 1'b1;
						ev.kind   = EV_PROGRAM;
						ev.data_a = d1;
					end
					ST_BEND: begin
						ev_hit    = 1'b1;
						ev.kind   = EV_BEND;
						ev.data_a = d1;
						ev.data_b = d2;
					end
					default: ev_hit = 1'b0;
				endcase
				ph_d     = PH_DELTA;
				varlen_d = '0;
				complete = 1'b1;
			end

			if (fin_meta) begin
				meta_len = varlen_d;
				if (meta_e == META_TEMPO && meta_len == 32'd3) begin
					if (!bpm_override) begin
						ev_hit   = 1'b1;
						ev.kind  = EV_TEMPO;
						ev.tempo = cap_d;
					end
				end else if (meta_e == META_TIMESIG && meta_len == 32'd4) begin
					ev_hit    = 1'b1;
					ev.kind   = EV_TIMESIG;
					ev.data_a = first_d;
					ev.data_b = cap_d[23:16];
				end else if (meta_e == META_EOT) begin
					ev_hit  = 1'b1;
					ev.kind = EV_ALLOFF;
					done_d  = 1'b1;
				end
				ph_d     = PH_DELTA;
				varlen_d = '0;
				complete = 1'b1;
			end

			if (head.last && !complete) err = 1'b1;
			if (err) begin
				ev_hit = 1'b1;
				ev     = '0;
				ev.kind = EV_ERROR;
				ph_d   = PH_IDLE;
				done_d = 1'b1;
			end else if (head.last) begin
				done_d = 1'b1;
			end
		end

		tick_ext = EXT_W'(tick_d);
		ev.tick  = tick_ext[OUT_TICK_W-1:0];
	end

	assign advance = qstat.not_empty && (!evt_valid_q || events.ready);
	assign pop     = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DELTA;
			run_q       <= '0;
			cur_q       <= '0;
			meta_q      <= '0;
			first_q     <= '0;
			varlen_q    <= '0;
			skip_q      <= '0;
			cap_q       <= '0;
			tick_q      <= '0;
			done_q      <= 1'b0;
			evt_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q  <= ph_d;
				run_q    <= run_d;
				cur_q    <= cur_d;
				meta_q   <= meta_d;
				first_q  <= first_d;
				varlen_q <= varlen_d;
				skip_q   <= skip_d;
				cap_q    <= cap_d;
				tick_q   <= tick_d;
				done_q   <= done_d;
			end
			if (advance && ev_hit) evt_valid_q <= 1'b1;
			else if (events.ready) evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ev_hit) evt_q <= ev;
	end

	assign events.valid       = evt_valid_q;
	assign events.event_kind  = evt_q.kind;
	assign events.channel     = evt_q.channel;
	assign events.data_a      = evt_q.data_a;
	assign events.data_b      = evt_q.data_b;
	assign events.tempo_usec  = evt_q.tempo;
	assign events.tick_offset = evt_q.tick;

endmodule

[rtl/smf_track_event_parser_top.sv]
// Top level of the MIDI file track event parser.
`timescale 1ns / 1ps
`include "smf_track_event_parser_top_assert.svh"
// Parses the body of a Standard MIDI File track chunk, one byte per request on
// the byte channel, and delivers note off, note on, control change,
// all-notes-off, program, pitch bend, tempo, time signature and error events
// on the event channel, each stamped with the absolute tick of the track.
// Throughput is one byte per clock while the result register is free or being
// taken: the front end classifies each byte into a two-entry queue, and the
// back-end parse state machine retires one queued byte per clock into a single
// result register. A byte's event passes through the queue and then the
// result register to the event channel. Back-pressure on the event channel
// stalls only the back end; the queue keeps the byte channel open until it
// fills. Tick counts are TICK_BITS wide and saturate; the reported tick is the
// low 48 bits. Write bpm_override only while the parser is idle.
module smf_track_event_parser_top
	import smf_tep_pkg::*;
#(
	parameter int TICK_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	smf_tep_in_if.sink    bytes,
	smf_tep_out_if.source events
);

	logic     bpm_override_q;
	logic     push;
	logic     pop;
	q_entry_t push_data;
	q_entry_t head;
	q_stat_t  qstat;

	// hold the tempo override until the next register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpm_override_q <= 1'b0;
		end else if (cfg_we) begin
			bpm_override_q <= cfg_wdata;
		end
	end

	// classify each byte and push it onto the queue
	smf_tep_front u_front (
		.bytes     (bytes),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// decouple byte intake from event delivery
	smf_tep_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// advance the parse state and register the resulting event
	smf_tep_back #(
		.TICK_BITS (TICK_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.bpm_override (bpm_override_q),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.events       (events)
	);

	// queue never holds more than its depth
	`SMF_TEP_ASSERT_NOW(a_queue_level, clk, arst_n, 1'b1, qstat.level <= Q_LVL_W'(Q_DEPTH))
	// back end only retires a byte that is queued
	`SMF_TEP_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, qstat.not_empty)
	// only tempo events carry a tempo value
	`SMF_TEP_ASSERT_NOW(a_tempo_only, clk, arst_n, events.valid && events.event_kind != EV_TEMPO, events.tempo_usec == '0)
	// a push without a pop grows the queue by one
	`SMF_TEP_ASSERT_NEXT(a_queue_grow, clk, arst_n, push && !pop, qstat.level == $past(qstat.level) + Q_LVL_W'(1))

endmodule

[bench/smf_tep_event_checker.sv]
// Event predictor and checker for the MIDI file track parser bench.
`timescale 1ns / 1ps
module smf_tep_event_checker
	import smf_tep_pkg::*;
#(
	parameter int TICK_BITS = 48
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   cfg_wdata,
	smf_tep_in_if  bytes_mon,
	smf_tep_out_if events_mon,
	output int     errors,
	output int     pending
);

	// Parser copy kept by the bench
	phase_t               phase = PH_DELTA;
	logic [7:0]           run_st = '0;
	logic [7:0]           cur_st = '0;
	logic [7:0]           meta_kind = '0;
	logic [7:0]           first_byte = '0;
	logic [31:0]          len_acc = '0;
	logic [31:0]          skip_left = '0;
	logic [23:0]          body_tail = '0;
	logic [TICK_BITS-1:0] ticks = '0;
	logic                 done = 1'b0;
	logic                 override = 1'b0;

	evt_t next_ev;
	logic ev_ready;
	evt_t expected_events[$];
	int   mismatches = 0;
	int   outstanding = 0;

	assign errors  = mismatches;
	assign pending = outstanding;

	function automatic logic two_data(input logic [7:0] st);
		return st[7:4] inside {ST_NOTEOFF, ST_NOTEON, ST_POLY_AT, ST_CC, ST_BEND};
	endfunction

	task automatic clear_state();
		phase      = PH_DELTA;
		run_st     = '0;
		cur_st     = '0;
		meta_kind  = '0;
		first_byte = '0;
		len_acc    = '0;
		skip_left  = '0;
		body_tail  = '0;
		ticks      = '0;
		done       = 1'b0;
	endtask

	task automatic set_event(input logic [3:0] kind, input logic [3:0] ch,
		input logic [7:0] a, input logic [7:0] b, input logic [23:0] usec);
		next_ev.kind    = kind;
		next_ev.channel = ch;
		next_ev.data_a  = a;
		next_ev.data_b  = b;
		next_ev.tempo   = usec;
		ev_ready        = 1'b1;
	endtask

	// Saturate at the top of the tick range
	task automatic add_ticks(input logic [31:0] delta);
		logic [TICK_BITS-1:0] room;
		room = {TICK_BITS{1'b1}} - ticks;
		if (TICK_BITS'(delta) > room)
			ticks = {TICK_BITS{1'b1}};
		else
			ticks = ticks + TICK_BITS'(delta);
	endtask

	task automatic close_channel(input logic [7:0] d1, input logic [7:0] d2);
		logic [3:0] ch;
		ch = cur_st[3:0];
		case (cur_st[7:4])
			ST_NOTEOFF: set_event(EV_NOTEOFF, ch, d1, 8'h00, 24'h0);
			ST_NOTEON: begin
				if (d2 == 8'h00)
					set_event(EV_NOTEOFF, ch, d1, 8'h00, 24'h0);
				else
					set_event(EV_NOTEON, ch, d1, d2, 24'h0);
			end
			ST_CC: begin
				if (d1 == CC_ALL_NOTES || d1 == CC_ALL_SOUND)
					set_event(EV_ALLOFF, ch, 8'h00, 8'h00, 24'h0);
				else
					set_event(EV_CC, ch, d1, d2, 24'h0);
			end
			ST_PROGRAM: set_event(EV_PROGRAM, ch, d1, 8'h00, 24'h0);
			ST_BEND: set_event(EV_BEND, ch, d1, d2, 24'h0);
			default: ;
		endcase
		phase   = PH_DELTA;
		len_acc = '0;
	endtask

	task automatic close_meta();
		if (meta_kind == META_TEMPO && len_acc == 32'd3) begin
			if (!override)
				set_event(EV_TEMPO, 4'h0, 8'h00, 8'h00, body_tail);
		end else if (meta_kind == META_TIMESIG && len_acc == 32'd4) begin
			set_event(EV_TIMESIG, 4'h0, first_byte, body_tail[23:16], 24'h0);
		end else if (meta_kind == META_EOT) begin
			set_event(EV_ALLOFF, 4'h0, 8'h00, 8'h00, 24'h0);
			done = 1'b1;
		end
		phase   = PH_DELTA;
		len_acc = '0;
	endtask

	// Advance the parser copy by one byte; queue the event it reports
	task automatic parse_byte(input logic [7:0] b, input logic start, input logic last);
		logic complete;
		logic fault;
		complete = 1'b0;
		fault    = 1'b0;
		ev_ready = 1'b0;
		if (start)
			clear_state();
		if (done || phase == PH_IDLE)
			return;
		case (phase)
			PH_DELTA: begin
				len_acc = {len_acc[24:0], b[6:0]};
				if (!b[7]) begin
					add_ticks(len_acc);
					phase = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (b == META_STATUS) begin
					phase = PH_META_TYPE;
				end else if (b == SYSEX_START || b == SYSEX_ESC) begin
					len_acc = '0;
					phase   = PH_SYSEX_LEN;
				end else if (!b[7]) begin
					if (run_st == 8'h00) begin
						fault = 1'b1;
					end else begin
						cur_st     = run_st;
						first_byte = b;
						if (two_data(cur_st)) begin
							phase = PH_DATA2;
						end else begin
							close_channel(b, 8'h00);
							complete = 1'b1;
						end
					end
				end else begin
					run_st = b;
					cur_st = b;
					phase  = PH_DATA1;
				end
			end
			PH_DATA1: begin
				first_byte = b;
				if (two_data(cur_st)) begin
					phase = PH_DATA2;
				end else begin
					close_channel(b, 8'h00);
					complete = 1'b1;
				end
			end
			PH_DATA2: begin
				close_channel(first_byte, b);
				complete = 1'b1;
			end
			PH_META_TYPE: begin
				meta_kind = b;
				len_acc   = '0;
				phase     = PH_META_LEN;
			end
			PH_META_LEN: begin
				len_acc = {len_acc[24:0], b[6:0]};
				if (!b[7]) begin
					skip_left  = len_acc;
					first_byte = '0;
					body_tail  = '0;
					if (skip_left == 32'd0) begin
						close_meta();
						complete = 1'b1;
					end else begin
						phase = PH_META_BODY;
					end
				end
			end
			PH_META_BODY: begin
				if (len_acc - skip_left == 32'd0)
					first_byte = b;
				body_tail = {body_tail[15:0], b};
				skip_left = skip_left - 32'd1;
				if (skip_left == 32'd0) begin
					close_meta();
					complete = 1'b1;
				end
			end
			PH_SYSEX_LEN: begin
				len_acc = {len_acc[24:0], b[6:0]};
				if (!b[7]) begin
					skip_left = len_acc;
					len_acc   = '0;
					if (skip_left == 32'd0) begin
						phase    = PH_DELTA;
						complete = 1'b1;
					end else begin
						phase = PH_SYSEX_BODY;
					end
				end
			end
			PH_SYSEX_BODY: begin
				skip_left = skip_left - 32'd1;
				if (skip_left == 32'd0) begin
					phase    = PH_DELTA;
					len_acc  = '0;
					complete = 1'b1;
				end
			end
			default: ;
		endcase
		if (last && !complete)
			fault = 1'b1;
		if (fault) begin
			set_event(EV_ERROR, 4'h0, 8'h00, 8'h00, 24'h0);
			phase = PH_IDLE;
			done  = 1'b1;
		end else if (last) begin
			done = 1'b1;
		end
		if (ev_ready) begin
			next_ev.tick = ticks[OUT_TICK_W-1:0];
			expected_events.push_back(next_ev);
			outstanding++;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_event();
		evt_t want;
		if (expected_events.size() == 0) begin
			$error("event_kind: expected none, got 0x%0h", events_mon.event_kind);
			mismatches++;
			return;
		end
		want = expected_events.pop_front();
		outstanding--;
		check_field("event_kind", 64'(want.kind), 64'(events_mon.event_kind));
		check_field("channel", 64'(want.channel), 64'(events_mon.channel));
		check_field("data_a", 64'(want.data_a), 64'(events_mon.data_a));
		check_field("data_b", 64'(want.data_b), 64'(events_mon.data_b));
		check_field("tempo_usec", 64'(want.tempo), 64'(events_mon.tempo_usec));
		check_field("tick_offset", 64'(want.tick), 64'(events_mon.tick_offset));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			override = 1'b0;
			expected_events.delete();
			outstanding = 0;
		end else begin
			// Outputs lag their byte, so retire before predicting
			if (events_mon.valid && events_mon.ready)
				check_event();
			if (bytes_mon.valid && bytes_mon.ready)
				parse_byte(bytes_mon.byte_value, bytes_mon.track_start,
					bytes_mon.last_in_track);
			if (cfg_we)
				override = cfg_wdata;
		end
	end

endmodule

[bench/tb_smf_track_event_parser_top.sv]
// Stimulus and verdict for the MIDI file track parser bench.
`timescale 1ns / 1ps
module tb_smf_track_event_parser_top;
	import smf_tep_pkg::*;

	localparam int TICK_BITS     = 48;
	localparam int CYCLE_LIMIT   = 40_000;
	localparam int SETTLE_CYCLES = 8;   // queue plus result register, with margin
	localparam int LONG_HOLD     = 120;
	localparam logic [3:0] ST_CH_PRESS = 4'hD;

	typedef struct {
		logic [7:0] value;
		logic       start;
		logic       last;
	} byte_req_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   errors;
	int   pending;
	int   cycle_count = 0;

	// Control shared with the receiver process; idle_mode and hold_asked are
	// written nonblocking so the receiver sees a settled value at each edge.
	logic idle_mode = 1'b1;
	int   hold_asked = 0;
	int   hold_taken = 0;
	int   hold_left = 0;
	int   stall_left = 0;

	byte_req_t  track_q[$];
	logic [7:0] gen_status;

	smf_tep_in_if  bytes_if();
	smf_tep_out_if events_if();

	smf_track_event_parser_top #(
		.TICK_BITS(TICK_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.bytes(bytes_if),
		.events(events_if)
	);

	smf_tep_event_checker #(
		.TICK_BITS(TICK_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.bytes_mon(bytes_if),
		.events_mon(events_if),
		.errors(errors),
		.pending(pending)
	);

	always #1 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_smf_track_event_parser_top: done, errors");
			$finish;
		end
	end

	// Event receiver: a long hold-off when asked, short random stalls while
	// idling is on, otherwise always ready.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			events_if.ready = 1'b0;
			hold_left--;
		end else if (hold_taken != hold_asked) begin
			events_if.ready = 1'b0;
			hold_taken++;
			hold_left = LONG_HOLD - 1;
		end else if (stall_left > 0) begin
			events_if.ready = 1'b0;
			stall_left--;
		end else if (idle_mode && $urandom_range(0, 5) == 0) begin
			events_if.ready = 1'b0;
			stall_left = $urandom_range(1, 5) - 1;
		end else begin
			events_if.ready = 1'b1;
		end
	end

	// Offer one byte request and hold it until it is taken. Enter and leave
	// at a falling edge; valid stays high into the next request.
	task automatic send_byte(input logic [7:0] value, input logic start, input logic last);
		int gap;
		if (idle_mode && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			bytes_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		bytes_if.valid         = 1'b1;
		bytes_if.byte_value    = value;
		bytes_if.track_start   = start;
		bytes_if.last_in_track = last;
		@(posedge clk);
		while (!bytes_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_track();
		foreach (track_q[i])
			send_byte(track_q[i].value, track_q[i].start, track_q[i].last);
		track_q.delete();
	endtask

	task automatic push_req(input logic [7:0] value);
		byte_req_t r;
		r.value = value;
		r.start = 1'b0;
		r.last  = 1'b0;
		track_q.push_back(r);
	endtask

	// Flag the track edges on the queued bytes
	task automatic mark_track(input logic with_last);
		track_q[0].start = 1'b1;
		if (with_last)
			track_q[track_q.size() - 1].last = 1'b1;
	endtask

	task automatic push_list(input logic [7:0] list[$]);
		foreach (list[i])
			push_req(list[i]);
	endtask

	function automatic logic [7:0] data_value();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 127));
	endfunction

	// Variable-length number of 1..max_len bytes with random content
	task automatic push_varlen(input int max_len);
		int n;
		n = $urandom_range(1, max_len);
		repeat (n - 1)
			push_req(8'h80 | 8'($urandom_range(0, 127)));
		push_req(8'($urandom_range(0, 127)));
	endtask

	// Length field, now and then with a redundant leading group
	task automatic push_length(input int len);
		if ($urandom_range(0, 7) == 0)
			push_req(8'h80);
		push_req(8'(len));
	endtask

	task automatic push_meta(input logic [7:0] kind, input int len);
		push_req(META_STATUS);
		push_req(kind);
		push_length(len);
		repeat (len)
			push_req(8'($urandom_range(0, 255)));
	endtask

	task automatic push_channel_msg();
		logic [7:0] st;
		logic [7:0] d;
		int pick;
		if (gen_status != 8'h00 && $urandom_range(0, 2) == 0) begin
			st = gen_status;   // lean on running status
		end else begin
			pick = $urandom_range(0, 15);
			case (pick)
				0, 1:    st = {ST_NOTEOFF, 4'($urandom_range(0, 15))};
				2, 3, 4: st = {ST_NOTEON, 4'($urandom_range(0, 15))};
				5:       st = {ST_POLY_AT, 4'($urandom_range(0, 15))};
				6, 7, 8: st = {ST_CC, 4'($urandom_range(0, 15))};
				9, 10:   st = {ST_PROGRAM, 4'($urandom_range(0, 15))};
				11:      st = {ST_CH_PRESS, 4'($urandom_range(0, 15))};
				12, 13:  st = {ST_BEND, 4'($urandom_range(0, 15))};
				default: begin
					st = 8'hF0 | 8'($urandom_range(1, 14));
					if (st == SYSEX_ESC)
						st = 8'hF1;
				end
			endcase
			push_req(st);
			gen_status = st;
		end
		d = data_value();
		if (st[7:4] == ST_CC && $urandom_range(0, 4) == 0)
			d = $urandom_range(0, 1) ? CC_ALL_NOTES : CC_ALL_SOUND;
		push_req(d);
		if (st[7:4] inside {ST_NOTEOFF, ST_NOTEON, ST_POLY_AT, ST_CC, ST_BEND}) begin
			d = data_value();
			if (st[7:4] == ST_NOTEON && $urandom_range(0, 4) == 0)
				d = 8'h00;
			push_req(d);
		end
	endtask

	task automatic push_event();
		int pick;
		int len;
		logic [7:0] kind;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			push_channel_msg();
		end else if (pick < 72) begin
			push_meta(META_TEMPO, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : 3);
		end else if (pick < 82) begin
			push_meta(META_TIMESIG, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : 4);
		end else if (pick < 90) begin
			kind = 8'($urandom_range(0, 255));
			if (kind inside {META_TEMPO, META_TIMESIG, META_EOT})
				kind = 8'h01;
			push_meta(kind, $urandom_range(0, 6));
		end else begin
			push_req($urandom_range(0, 1) ? SYSEX_START : SYSEX_ESC);
			len = $urandom_range(0, 6);
			push_length(len);
			repeat (len)
				push_req(8'($urandom_range(0, 255)));
		end
	endtask

	// Build one well-formed track of n events, sometimes broken by noise,
	// ended by end-of-track, by the last-byte flag, by truncation or not at all.
	task automatic build_track(input int n_events);
		int ending;
		int cut;
		gen_status = 8'h00;
		for (int i = 0; i < n_events; i++) begin
			push_varlen(($urandom_range(0, 9) == 0) ? 7 : 2);
			if ($urandom_range(0, 19) == 0)
				push_req(8'($urandom_range(0, 255)));
			push_event();
		end
		ending = $urandom_range(0, 3);
		case (ending)
			0: begin
				push_req(8'h00);
				push_meta(META_EOT, 0);
				repeat ($urandom_range(0, 2))
					push_req(8'($urandom_range(0, 255)));
				mark_track(1'($urandom_range(0, 1)));
			end
			1: mark_track(1'b1);
			2: begin
				cut = $urandom_range(1, 3);
				while (cut > 0 && track_q.size() > 1) begin
					track_q.delete(track_q.size() - 1);
					cut--;
				end
				mark_track(1'b1);
			end
			default: mark_track(1'b0);
		endcase
	endtask

	task automatic run_segment(input int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			build_track($urandom_range(1, 10));
			sent += track_q.size();
			send_track();
		end
	endtask

	// Drain every expected event, let bytes that report nothing clear the
	// pipe, then write the override register.
	task automatic settle_and_set(input logic value);
		bytes_if.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
	endtask

	task automatic run_directed();
		// Note on with velocity zero, a delta longer than 32 bits under
		// running status, both all-notes-off controllers, the dropped
		// messages, a wrong-length tempo, then end-of-track and a dead byte.
		push_list('{8'h00, 8'h90, 8'h00, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h3C, 8'hFF,
			8'h00, 8'hBF, 8'h7B, 8'h55, 8'h00, 8'h78, 8'h01,
			8'h00, 8'hA5, 8'h01, 8'h02, 8'h00, 8'hD3, 8'h40, 8'h00, 8'hF5, 8'h09,
			8'h00, 8'hFF, 8'h51, 8'h02, 8'h01, 8'h02,
			8'h00, 8'hFF, 8'h2F, 8'h00, 8'h90});
		mark_track(1'b0);
		send_track();
		// Data byte with no running status: error, then silence
		push_list('{8'h00, 8'h40, 8'h00});
		mark_track(1'b0);
		send_track();
		// Event cut short by the last byte
		push_list('{8'h00, 8'h90, 8'h3C});
		mark_track(1'b1);
		send_track();
		// Delta time cut short on a one-byte track
		push_list('{8'h80});
		mark_track(1'b1);
		send_track();

		settle_and_set(1'b1);
		// Tempo suppressed, short time signature skipped, full-range fields
		push_list('{8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'hFF, 8'h58, 8'h03, 8'h01, 8'h02, 8'h03,
			8'h00, 8'hFF, 8'h58, 8'h04, 8'hFF, 8'h00, 8'hFF, 8'h01,
			8'h00, 8'hB0, 8'h07, 8'h7F, 8'h00, 8'hE0, 8'h00, 8'h00,
			8'h00, 8'hCF, 8'h7F});
		mark_track(1'b1);
		send_track();

		settle_and_set(1'b0);
		push_list('{8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'hFF, 8'h51, 8'h03, 8'h00, 8'h00, 8'h00});
		mark_track(1'b1);
		send_track();
	endtask

	// Push the tick count up with maximal five-byte deltas, each followed by
	// one channel pressure byte under running status, then two notes.
	task automatic run_long_deltas();
		logic [3:0] ch;
		ch = 4'($urandom_range(0, 15));
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte({ST_CH_PRESS, ch}, 1'b0, 1'b0);
		send_byte(8'($urandom_range(0, 127)), 1'b0, 1'b0);
		for (int i = 0; i < 6; i++) begin
			repeat (4) send_byte(8'hFF, 1'b0, 1'b0);
			send_byte(8'h7F, 1'b0, 1'b0);
			send_byte(8'($urandom_range(0, 127)), 1'b0, 1'b0);
		end
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte({ST_NOTEON, ch}, 1'b0, 1'b0);
		send_byte(8'h40, 1'b0, 1'b0);
		send_byte(8'h40, 1'b0, 1'b0);
		send_byte(8'h7F, 1'b0, 1'b0);
		send_byte(8'h41, 1'b0, 1'b0);
		send_byte(8'h41, 1'b0, 1'b1);
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = 1'b0;
		bytes_if.valid         = 1'b0;
		bytes_if.byte_value    = 8'h00;
		bytes_if.track_start   = 1'b0;
		bytes_if.last_in_track = 1'b0;
		events_if.ready        = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		settle_and_set(1'b0);
		run_segment(40);

		// Hold the receiver off while a dense track keeps coming
		settle_and_set(1'b1);
		hold_asked <= hold_asked + 1;
		build_track(12);
		send_track();
		run_segment(40);

		// A stretch with no idling on either side
		settle_and_set(1'b0);
		idle_mode <= 1'b0;
		run_segment(60);

		settle_and_set(1'b1);
		idle_mode <= 1'b1;
		run_segment(60);

		// Final part: no idling at all
		settle_and_set(1'b0);
		idle_mode <= 1'b0;
		run_long_deltas();
		run_segment(30);

		bytes_if.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("tb_smf_track_event_parser_top: done, clean");
		else
			$display("tb_smf_track_event_parser_top: done, errors");
		$finish;
	end

endmodule

[smf_track_event_parser_top.f]
+incdir+rtl
rtl/smf_tep_pkg.sv
rtl/smf_tep_in_if.sv
rtl/smf_tep_out_if.sv
rtl/smf_tep_front.sv
rtl/smf_tep_queue.sv
rtl/smf_tep_back.sv
rtl/smf_track_event_parser_top.sv
bench/smf_tep_event_checker.sv
bench/tb_smf_track_event_parser_top.sv
